/* rtl/pir_pkg.sv */
package pir_pkg;

	localparam logic [2:0] KIND_BEGIN   = 3'd0;
	localparam logic [2:0] KIND_HEADER  = 3'd1;
	localparam logic [2:0] KIND_DATA    = 3'd2;
	localparam logic [2:0] KIND_DISCARD = 3'd3;
	localparam logic [2:0] KIND_READ    = 3'd4;

	localparam logic [2:0] ST_OK     = 3'd0;
	localparam logic [2:0] ST_DUP    = 3'd1;
	localparam logic [2:0] ST_NOIMG  = 3'd2;
	localparam logic [2:0] ST_ORDER  = 3'd3;
	localparam logic [2:0] ST_OVER   = 3'd4;
	localparam logic [2:0] ST_BADCNT = 3'd5;

	localparam int IN_DATA_W  = 64;
	localparam int OUT_DATA_W = 32;

	typedef struct packed {
		logic [13:0] packet_count;
		logic [13:0] packet_number;
		logic [11:0] packet_length;
		logic [7:0]  data_byte;
		logic [15:0] read_address;
	} item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic        complete;
		logic [16:0] image_length;
		logic        read_hit;
	} result_t;

endpackage

/* rtl/packet_image_reassembler.sv */
// Channel  Direction  Handshake          Payload
// s        in         s_tvalid/s_tready  s_tdata (item fields), s_tuser (kind)
// m        out        m_tvalid/m_tready  m_tdata (status, completion, length, byte)
//
// One item enters per cycle, unless a stalled output holds s_tready low, and gives one result.
// Stage one updates the image state and issues the store write or read; stage two
// collects the registered read byte into the output register.
// The image store is one single-port memory; each item uses it at most once.
// Reset clears the control state at once; the store content is not cleared.
// A stalled output fills the pipeline, then s_tready drops until m_tready returns.
module packet_image_reassembler
	import pir_pkg::*;
#(
	parameter int BUFFER_BYTES = 65536,
	parameter int MAX_PACKETS  = 8192,
	parameter int PACKET_ROOM  = 2048
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// packet_count[13:0], packet_number[27:14], packet_length[39:28],
	// data_byte[47:40], read_address[63:48]
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// kind[2:0]
	input  logic [2:0]            s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// status[2:0], complete[3], image_length[20:4], read_data[28:21], zero above
	output logic [OUT_DATA_W-1:0] m_tdata
);

	localparam int AW = $clog2(BUFFER_BYTES);

	item_t                  item;
	result_t                res;
	result_t                res_s1;
	logic                   v_s1;
	logic                   m_valid_q;
	logic [OUT_DATA_W-1:0]  m_data_q;
	logic                   out_free;
	logic                   accept;
	logic                   ram_en;
	logic                   ram_we;
	logic [AW-1:0]          ram_addr;
	logic [7:0]             ram_wdata;
	logic [7:0]             ram_rdata;
	logic [7:0]             read_byte;

	assign item.packet_count  = s_tdata[13:0];
	assign item.packet_number = s_tdata[27:14];
	assign item.packet_length = s_tdata[39:28];
	assign item.data_byte     = s_tdata[47:40];
	assign item.read_address  = s_tdata[63:48];

	assign out_free = !m_valid_q || m_tready;
	assign s_tready = !v_s1 || out_free;
	assign accept   = s_tvalid && s_tready;

	pir_ctrl #(
		.BUFFER_BYTES(BUFFER_BYTES),
		.MAX_PACKETS (MAX_PACKETS),
		.PACKET_ROOM (PACKET_ROOM)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.kind     (s_tuser),
		.item     (item),
		.res      (res),
		.ram_en   (ram_en),
		.ram_we   (ram_we),
		.ram_addr (ram_addr),
		.ram_wdata(ram_wdata)
	);

	pir_ram #(
		.WIDTH(8),
		.DEPTH(BUFFER_BYTES)
	) u_store (
		.clk  (clk),
		.en   (ram_en),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1 <= res;
		end
	end

	assign read_byte = res_s1.read_hit ? ram_rdata : 8'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_free) begin
			m_valid_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && v_s1) begin
			m_data_q <= {3'd0, read_byte, res_s1.image_length, res_s1.complete,
				res_s1.status};
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> v_s1 && m_valid_q && !m_tready)
		else $error("Input is stalled while the pipeline has room.");

	a_s1_moves: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && out_free |=> m_valid_q)
		else $error("A stage one item was lost on its way to the output.");

	a_complete_ok: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && res_s1.complete |-> res_s1.status != ST_BADCNT
			&& res_s1.status != ST_ORDER && res_s1.status != ST_OVER)
		else $error("Completion reported on an item that dropped the image.");

endmodule

/* rtl/pir_ram.sv */
module pir_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem_q[addr] <= wdata;
			end else begin
				rdata <= mem_q[addr];
			end
		end
	end

endmodule

/* rtl/pir_ctrl.sv */
module pir_ctrl
	import pir_pkg::*;
#(
	parameter int BUFFER_BYTES = 65536,
	parameter int MAX_PACKETS  = 8192,
	parameter int PACKET_ROOM  = 2048
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            accept,
	input  logic [2:0]                      kind,
	input  item_t                           item,
	output result_t                         res,
	output logic                            ram_en,
	output logic                            ram_we,
	output logic [$clog2(BUFFER_BYTES)-1:0] ram_addr,
	output logic [7:0]                      ram_wdata
);

	localparam int AW = $clog2(BUFFER_BYTES);
	localparam int LW = $clog2(BUFFER_BYTES + 1);
	localparam int CW = 14 + $clog2(PACKET_ROOM + 1) + 1;
	localparam int SW = LW + 1;
	localparam int RW = LW + 16;

	logic          active_q, active_d;
	logic          skip_q, skip_d;
	logic [LW-1:0] stored_q, stored_d;
	logic [LW-1:0] cap_q, cap_d;
	logic [13:0]   expected_q, expected_d;
	logic [14:0]   next_q, next_d;
	logic [11:0]   remain_q, remain_d;
	logic [CW-1:0] cap_w;
	logic [SW-1:0] end_w;
	logic [2:0]    status;
	logic          do_write;

	assign cap_w = (CW'(item.packet_count) + CW'(1)) * CW'(PACKET_ROOM);
	assign end_w = SW'(stored_q) + SW'(item.packet_length);

	always_comb begin
		active_d   = active_q;
		skip_d     = skip_q;
		stored_d   = stored_q;
		cap_d      = cap_q;
		expected_d = expected_q;
		next_d     = next_q;
		remain_d   = remain_q;
		status     = ST_OK;
		do_write   = 1'b0;
		unique case (kind)
			KIND_BEGIN: begin
				active_d   = 1'b0;
				skip_d     = 1'b0;
				stored_d   = '0;
				cap_d      = '0;
				expected_d = '0;
				next_d     = '0;
				remain_d   = '0;
				if (item.packet_count == 14'd0 || 32'(item.packet_count) > MAX_PACKETS
						|| cap_w > CW'(BUFFER_BYTES)) begin
					status = ST_BADCNT;
				end else begin
					active_d   = 1'b1;
					cap_d      = LW'(cap_w);
					expected_d = item.packet_count;
					next_d     = 15'd1;
				end
			end
			KIND_HEADER: begin
				if (!active_q) begin
					status = ST_NOIMG;
				end else if ({1'b0, item.packet_number} + 15'd1 == next_q) begin
					status   = ST_DUP;
					skip_d   = 1'b1;
					remain_d = item.packet_length;
				end else if ({1'b0, item.packet_number} != next_q
						|| end_w > SW'(cap_q)) begin
					status     = ({1'b0, item.packet_number} != next_q) ? ST_ORDER : ST_OVER;
					active_d   = 1'b0;
					skip_d     = 1'b0;
					stored_d   = '0;
					cap_d      = '0;
					expected_d = '0;
					next_d     = '0;
					remain_d   = '0;
				end else begin
					skip_d   = 1'b0;
					remain_d = item.packet_length;
					next_d   = next_q + 15'd1;
				end
			end
			KIND_DATA: begin
				if (!active_q) begin
					status = ST_NOIMG;
				end else if (remain_q != 12'd0) begin
					if (!skip_q && 32'(stored_q) < BUFFER_BYTES) begin
						do_write = 1'b1;
						stored_d = stored_q + LW'(1);
					end
					remain_d = remain_q - 12'd1;
					if (remain_q == 12'd1) begin
						skip_d = 1'b0;
					end
				end
			end
			KIND_DISCARD: begin
				active_d   = 1'b0;
				skip_d     = 1'b0;
				stored_d   = '0;
				cap_d      = '0;
				expected_d = '0;
				next_d     = '0;
				remain_d   = '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q   <= 1'b0;
			skip_q     <= 1'b0;
			stored_q   <= '0;
			cap_q      <= '0;
			expected_q <= '0;
			next_q     <= '0;
			remain_q   <= '0;
		end else if (accept) begin
			active_q   <= active_d;
			skip_q     <= skip_d;
			stored_q   <= stored_d;
			cap_q      <= cap_d;
			expected_q <= expected_d;
			next_q     <= next_d;
			remain_q   <= remain_d;
		end
	end

	assign res.status       = status;
	assign res.complete     = active_d && expected_d != 14'd0
		&& next_d > {1'b0, expected_d} && remain_d == 12'd0;
	assign res.image_length = 17'(stored_d);
	assign res.read_hit     = (kind == KIND_READ)
		&& (RW'(item.read_address) < RW'(stored_q));

	assign ram_en    = accept && (do_write || kind == KIND_READ);
	assign ram_we    = do_write;
	assign ram_addr  = do_write ? stored_q[AW-1:0] : AW'(item.read_address);
	assign ram_wdata = item.data_byte;

	a_len_in_cap: assert property (@(posedge clk) disable iff (!arst_n)
		stored_q <= cap_q)
		else $error("Stored length exceeds the reserved capacity.");

	a_idle_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!active_q |-> stored_q == '0 && next_q == '0 && remain_q == '0)
		else $error("Image state is left over without an active image.");

	a_skip_active: assert property (@(posedge clk) disable iff (!arst_n)
		skip_q |-> active_q)
		else $error("Duplicate skipping is set without an active image.");

	a_write_room: assert property (@(posedge clk) disable iff (!arst_n)
		accept && do_write |=> stored_q == $past(stored_q) + LW'(1))
		else $error("A stored byte did not advance the stored length.");

endmodule

/* tb/reassembly_checker.sv */
module reassembly_checker
	import pir_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,
	input  logic [2:0]            s_tuser,
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [OUT_DATA_W-1:0] m_tdata,
	output int                    pending,
	output int                    errors
);

	localparam int BUFFER_BYTES = 65536;
	localparam int MAX_PACKETS  = 8192;
	localparam int PACKET_ROOM  = 2048;

	typedef struct packed {
		logic [2:0]  pad;
		logic [7:0]  rd_byte;
		logic [16:0] length;
		logic        complete;
		logic [2:0]  status;
	} outcome_t;

	logic        img_active;
	logic        skip_dup;
	logic [16:0] stored_len;
	logic [16:0] cap_bytes;
	logic [13:0] exp_packets;
	logic [14:0] next_pkt;
	logic [11:0] bytes_left;
	logic [7:0]  image_bytes [BUFFER_BYTES];
	outcome_t    outcome_q [$];
	int          result_no;

	function void drop_image();
		img_active  = 1'b0;
		skip_dup    = 1'b0;
		stored_len  = '0;
		cap_bytes   = '0;
		exp_packets = '0;
		next_pkt    = '0;
		bytes_left  = '0;
	endfunction

	function void reassemble(input logic [2:0] kind, input logic [63:0] payload,
			output outcome_t res);
		logic [13:0] total;
		logic [13:0] pnum;
		logic [11:0] plen;
		logic [7:0]  dbyte;
		logic [15:0] addr;
		int          cap;
		total = payload[13:0];
		pnum  = payload[27:14];
		plen  = payload[39:28];
		dbyte = payload[47:40];
		addr  = payload[63:48];
		res   = '0;
		case (kind)
			KIND_BEGIN: begin
				cap = int'(total) * PACKET_ROOM + PACKET_ROOM;
				drop_image();
				if (total == 0 || int'(total) > MAX_PACKETS || cap > BUFFER_BYTES) begin
					res.status = ST_BADCNT;
				end else begin
					img_active  = 1'b1;
					cap_bytes   = cap[16:0];
					exp_packets = total;
					next_pkt    = 15'd1;
				end
			end
			KIND_HEADER: begin
				if (!img_active) begin
					res.status = ST_NOIMG;
				end else if (int'(pnum) + 1 == int'(next_pkt)) begin
					res.status = ST_DUP;
					skip_dup   = 1'b1;
					bytes_left = plen;
				end else if ({1'b0, pnum} != next_pkt) begin
					drop_image();
					res.status = ST_ORDER;
				end else if (int'(stored_len) + int'(plen) > int'(cap_bytes)) begin
					drop_image();
					res.status = ST_OVER;
				end else begin
					skip_dup   = 1'b0;
					bytes_left = plen;
					next_pkt   = next_pkt + 15'd1;
				end
			end
			KIND_DATA: begin
				if (!img_active) begin
					res.status = ST_NOIMG;
				end else if (bytes_left != 0) begin
					if (!skip_dup && int'(stored_len) < BUFFER_BYTES) begin
						image_bytes[stored_len[15:0]] = dbyte;
						stored_len = stored_len + 17'd1;
					end
					bytes_left = bytes_left - 12'd1;
					if (bytes_left == 0) begin
						skip_dup = 1'b0;
					end
				end
			end
			KIND_DISCARD: begin
				drop_image();
			end
			KIND_READ: begin
				if (int'(addr) < int'(stored_len)) begin
					res.rd_byte = image_bytes[addr];
				end
			end
			default: begin
			end
		endcase
		res.complete = img_active && exp_packets != 0 && next_pkt > {1'b0, exp_packets} &&
			bytes_left == 0;
		res.length = stored_len;
	endfunction

	task report(input string msg);
		$display("t=%0t result %0d: %s", $time, result_no, msg);
		errors++;
	endtask

	task check_field(input string name, input logic [16:0] got, input logic [16:0] want);
		if (got !== want) begin
			report($sformatf("%s is %0d, expected %0d", name, got, want));
		end
	endtask

	initial begin
		drop_image();
		pending   = 0;
		errors    = 0;
		result_no = 0;
	end

	always @(posedge clk) begin
		outcome_t got;
		outcome_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got = m_tdata;
				if (outcome_q.size() == 0) begin
					report("result arrived with no item outstanding");
				end else begin
					want = outcome_q.pop_front();
					check_field("status", 17'(got.status), 17'(want.status));
					check_field("complete", 17'(got.complete), 17'(want.complete));
					check_field("image_length", got.length, want.length);
					check_field("read_data", 17'(got.rd_byte), 17'(want.rd_byte));
					check_field("upper padding", 17'(got.pad), 17'(want.pad));
				end
				result_no++;
			end
			if (s_tvalid && s_tready) begin
				reassemble(s_tuser, s_tdata, want);
				outcome_q.push_back(want);
			end
			pending = outcome_q.size();
		end
	end

endmodule

/* tb/testbench.sv */
module testbench;
	import pir_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam logic [2:0] KIND_LAST = 3'd7;

	logic                  clk      = 1'b0;
	logic                  arst_n   = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata  = '0;
	logic [2:0]            s_tuser  = KIND_BEGIN;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;

	int pending;
	int errors;
	int idle_pct  = 0;
	int stall_pct = 0;
	int sent      = 0;
	int cycles    = 0;

	packet_image_reassembler dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	reassembly_checker u_check (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.pending  (pending),
		.errors   (errors)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	task automatic send(input logic [2:0] kind, input logic [63:0] payload);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= payload;
		do @(posedge clk); while (!s_tready);
		sent++;
	endtask

	task automatic begin_image(input int count);
		logic [63:0] p;
		p = {$urandom, $urandom};
		p[13:0] = count[13:0];
		send(KIND_BEGIN, p);
	endtask

	task automatic header(input int num, input int len);
		logic [63:0] p;
		p = {$urandom, $urandom};
		p[27:14] = num[13:0];
		p[39:28] = len[11:0];
		send(KIND_HEADER, p);
	endtask

	task automatic put_byte(input logic [7:0] b);
		logic [63:0] p;
		p = {$urandom, $urandom};
		p[47:40] = b;
		send(KIND_DATA, p);
	endtask

	task automatic read_at(input int addr);
		logic [63:0] p;
		p = {$urandom, $urandom};
		p[63:48] = addr[15:0];
		send(KIND_READ, p);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		@(posedge clk);
	endtask

	task automatic directed();
		header(7, 3);
		put_byte(8'h3C);
		begin_image(0);
		begin_image(32);
		begin_image(16383);
		begin_image(31);
		header(0, 5);
		put_byte(8'h11);
		header(1, 2);
		put_byte(8'h00);
		put_byte(8'hFF);
		put_byte(8'hA5);
		read_at(0);
		read_at(1);
		read_at(2);
		read_at(16'hFFFF);
		header(1, 1);
		put_byte(8'h55);
		header(3, 0);
		begin_image(1);
		header(1, 2);
		put_byte(8'h80);
		put_byte(8'h7F);
		header(2, 12'hFFF);
		send(KIND_DISCARD, {$urandom, $urandom});
		for (int k = KIND_READ + 1; k <= KIND_LAST; k++) begin
			send(3'(k), {$urandom, $urandom});
		end
	endtask

	// A well-formed image most of the time, with duplicates, stray bytes,
	// abandoned packets, wrong numbers and overruns mixed in.
	task automatic run_image();
		int count;
		int last;
		int len;
		int n;
		int est;
		int roll;
		count = ($urandom_range(9) == 0) ? $urandom_range(1, 31) : $urandom_range(1, 5);
		last  = count + (($urandom_range(7) == 0) ? 1 : 0);
		est   = 0;
		begin_image(count);
		for (int pkt = 1; pkt <= last; pkt++) begin
			roll = $urandom_range(99);
			if (roll < 4) begin
				header(pkt + 1 + $urandom_range(0, 3), $urandom_range(0, 4095));
				return;
			end
			len = (roll < 15) ? $urandom_range(0, 4095) : $urandom_range(0, 12);
			header(pkt, len);
			n = (len <= 12) ? len : $urandom_range(0, 6);
			for (int i = 0; i < n; i++) begin
				put_byte(8'($urandom_range(255)));
				if ($urandom_range(15) == 0) begin
					read_at($urandom_range(0, est + i + 1));
				end
			end
			est += n;
			if ($urandom_range(9) == 0) begin
				len = $urandom_range(0, 4);
				header(pkt, len);
				repeat ($urandom_range(0, len)) put_byte(8'($urandom_range(255)));
			end
			if ($urandom_range(9) == 0) begin
				put_byte(8'($urandom_range(255)));
			end
			if ($urandom_range(3) == 0) begin
				read_at($urandom_range(0, est + 1));
			end
		end
		if ($urandom_range(6) == 0) begin
			header(last + 1, 4095 - $urandom_range(0, 2));
		end
		repeat ($urandom_range(1, 3)) begin
			read_at(($urandom_range(3) == 0) ? $urandom_range(0, 65535) :
				$urandom_range(0, est + 1));
		end
		if ($urandom_range(3) == 0) begin
			send(KIND_DISCARD, {$urandom, $urandom});
		end
	endtask

	initial begin
		int target;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		directed();
		drain();
		for (int ph = 0; ph < 4; ph++) begin
			idle_pct  = (ph == 1) ? 78 : (ph == 3) ? 8 : 0;
			stall_pct = (ph == 2) ? 78 : (ph == 3) ? 8 : 0;
			target    = sent + 170;
			while (sent < target) begin
				if ($urandom_range(4) == 0) begin
					repeat ($urandom_range(1, 4)) send(3'($urandom_range(7)), {$urandom, $urandom});
				end else begin
					run_image();
				end
			end
			drain();
		end
		repeat (8) @(posedge clk);
		if (errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

/* packet_image_reassembler.f */
rtl/pir_pkg.sv
rtl/pir_ram.sv
rtl/pir_ctrl.sv
rtl/packet_image_reassembler.sv
tb/reassembly_checker.sv
tb/testbench.sv
